@@ rtl/core/tosc_pkg.sv @@
// Shared constants, codes and types of the tracked object speed classifier.
package tosc_pkg;

   localparam int MAX_OBJECTS_DEF  = 64;
   localparam int WINDOW_DEPTH_DEF = 16;
   localparam int AVG_COUNT        = 3;
   localparam int MIN_FILL         = 8;
   localparam int POS_WIDTH        = 32;
   localparam int ACC_W            = POS_WIDTH + 4;
   localparam int NUM_W            = ACC_W + 4;
   localparam int K_W              = $clog2(2 * AVG_COUNT + 1);

   localparam logic [1:0] CMD_OBSERVE = 2'd0;
   localparam logic [1:0] CMD_ADVANCE = 2'd1;
   localparam logic [1:0] CMD_PURGE   = 2'd2;

   localparam logic [1:0] STAT_UPDATED = 2'd0;
   localparam logic [1:0] STAT_REPEAT  = 2'd1;
   localparam logic [1:0] STAT_NEW     = 2'd2;
   localparam logic [1:0] STAT_FULL    = 2'd3;

   localparam logic [1:0] MV_UNKNOWN = 2'd0;
   localparam logic [1:0] MV_STABLE  = 2'd1;
   localparam logic [1:0] MV_FASTER  = 2'd2;
   localparam logic [1:0] MV_SLOWER  = 2'd3;

   localparam logic CSR_DEADBAND = 1'b0;
   localparam logic CSR_WLIMIT   = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_GAP,
      S_SCAN,
      S_RESOLVE,
      S_APPEND,
      S_RD,
      S_ACC,
      S_DIV_GO,
      S_DIV_WAIT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

@@ rtl/core/tosc_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned operands.
module tosc_div #(
   parameter int NUM_W_P = tosc_pkg::NUM_W,
   parameter int DEN_W_P = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [NUM_W_P-1:0]      num,
   input  logic [DEN_W_P-1:0]      den,
   output logic [NUM_W_P-1:0]      quot,
   output tosc_pkg::div_sts_type   sts
);
   import tosc_pkg::*;

   localparam int CW = $clog2(NUM_W_P + 1);

   logic [DEN_W_P:0]   rem_ff, rem_in;
   logic [NUM_W_P-1:0] rq_ff, rq_in;
   logic [DEN_W_P-1:0] den_ff, den_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W_P:0]   rem_sh;

   always_comb begin
      rem_in  = rem_ff;
      rq_in   = rq_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[DEN_W_P-1:0], rq_ff[NUM_W_P-1]};
      if (start) begin
         rem_in  = '0;
         rq_in   = num;
         den_in  = den;
         cnt_in  = CW'(NUM_W_P);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            rq_in  = {rq_ff[NUM_W_P-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            rq_in  = {rq_ff[NUM_W_P-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      rq_ff  <= rq_in;
      den_ff <= den_in;
   end

   assign quot     = rq_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

@@ rtl/core/tracked_object_speed_classifier.sv @@
// Top level: object table, history window and speed estimate sequencer.
// Purge and observe walk the table one slot a cycle; an observe that estimates a speed
// also runs the bit-serial divider. One transaction at a time: the next is taken once
// the result is registered, and a result may wait while the next is taken.
// Reset clears control state, config, valid bits and sequence stamp; tables are not swept.
module tracked_object_speed_classifier #(
   parameter int MAX_OBJECTS  = tosc_pkg::MAX_OBJECTS_DEF,
   parameter int WINDOW_DEPTH = tosc_pkg::WINDOW_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [30:0]        req_obstacle_id,
   input  logic signed [31:0] req_obj_start_pos,
   input  logic signed [31:0] req_obj_end_pos,
   input  logic signed [31:0] req_ego_start_pos,
   input  logic signed [31:0] req_ego_end_pos,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_move_state,
   output logic signed [31:0] rsp_gap_rate,
   output logic               rsp_speed_valid,
   output logic [1:0]         rsp_status,
   output logic [6:0]         rsp_removed_count,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [30:0]        csr_wdata
);
   import tosc_pkg::*;

   localparam int SW    = $clog2(MAX_OBJECTS);
   localparam int HW    = $clog2(WINDOW_DEPTH);
   localparam int FW    = $clog2(WINDOW_DEPTH + 1);
   localparam int HAW   = $clog2(MAX_OBJECTS * WINDOW_DEPTH);
   localparam int DEN_W = $clog2(AVG_COUNT * WINDOW_DEPTH + 1);
   localparam logic signed [33:0] GAP_MAX = (34'sd1 <<< (POS_WIDTH - 1)) - 34'sd1;
   localparam logic signed [33:0] GAP_MIN = -(34'sd1 <<< (POS_WIDTH - 1));

   function automatic logic [HW-1:0] wrap_idx(input logic [HW-1:0] h, input logic [FW-1:0] p);
      logic [FW:0] s;
      s = (FW+1)'(h) + (FW+1)'(p);
      if (s >= (FW+1)'(WINDOW_DEPTH)) s = s - (FW+1)'(WINDOW_DEPTH);
      return s[HW-1:0];
   endfunction

   // memories
   logic [30:0]          ident_mem [MAX_OBJECTS];
   logic [31:0]          stamp_mem [MAX_OBJECTS];
   logic [FW-1:0]        fill_mem  [MAX_OBJECTS];
   logic [HW-1:0]        head_mem  [MAX_OBJECTS];
   logic signed [31:0]   spd_mem   [MAX_OBJECTS];
   logic                 ok_mem    [MAX_OBJECTS];
   logic signed [POS_WIDTH-1:0] hist_mem [MAX_OBJECTS * WINDOW_DEPTH];

   logic                 meta_we;
   logic [SW-1:0]        meta_wa, meta_ra;
   logic [31:0]          w_stamp;
   logic [FW-1:0]        w_fill;
   logic [HW-1:0]        w_head;
   logic signed [31:0]   w_spd;
   logic                 w_ok;
   logic [30:0]          q_ident;
   logic [31:0]          q_stamp;
   logic [FW-1:0]        q_fill;
   logic [HW-1:0]        q_head;
   logic signed [31:0]   q_spd;
   logic                 q_ok;
   logic                 hist_we;
   logic [HAW-1:0]       hist_wa, hist_ra;
   logic signed [POS_WIDTH-1:0] hist_q;

   // control and datapath registers
   state_type            state_ff, state_in;
   logic [1:0]           cmd_ff, cmd_in;
   logic [30:0]          id_ff, id_in;
   logic signed [31:0]   os_ff, os_in, oe_ff, oe_in, es_ff, es_in, ee_ff, ee_in;
   logic signed [POS_WIDTH-1:0] gap_ff, gap_in;
   logic [31:0]          seq_ff, seq_in;
   logic [30:0]          deadband_ff;
   logic [4:0]           wlimit_ff;
   logic [MAX_OBJECTS-1:0] valid_ff;
   logic                 vset, vclr;
   logic [SW-1:0]        vset_idx, vclr_idx;
   logic [SW-1:0]        scan_idx_ff, scan_idx_in, cmp_idx_ff, cmp_idx_in;
   logic                 issue_done_ff, issue_done_in, cmp_pend_ff, cmp_pend_in;
   logic                 found_ff, found_in, free_ok_ff, free_ok_in;
   logic [SW-1:0]        free_idx_ff, free_idx_in, slot_ff, slot_in;
   logic [31:0]          m_stamp_ff, m_stamp_in;
   logic [FW-1:0]        m_fill_ff, m_fill_in, nfill_ff, nfill_in;
   logic [HW-1:0]        m_head_ff, m_head_in, nhead_ff, nhead_in;
   logic signed [31:0]   m_spd_ff, m_spd_in;
   logic                 m_ok_ff, m_ok_in;
   logic [6:0]           cnt_ff, cnt_in;
   logic [K_W-1:0]       rd_k_ff, rd_k_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                 neg_ff, neg_in;
   logic [1:0]           r_move_ff, r_move_in, r_stat_ff, r_stat_in;
   logic signed [31:0]   r_spd_ff, r_spd_in;
   logic                 r_sv_ff, r_sv_in;
   logic [6:0]           r_rem_ff, r_rem_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_move_ff, rsp_move_in, rsp_stat_ff, rsp_stat_in;
   logic signed [31:0]   rsp_spd_ff, rsp_spd_in;
   logic                 rsp_sv_ff, rsp_sv_in;
   logic [6:0]           rsp_rem_ff, rsp_rem_in;

   // divider
   logic                 div_start;
   logic [NUM_W-1:0]     div_num, div_quot;
   logic [DEN_W-1:0]     div_den;
   div_sts_type          div_sts;

   tosc_div #(.NUM_W_P(NUM_W), .DEN_W_P(DEN_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quot  (div_quot),
      .sts   (div_sts)
   );

   // scratch
   logic signed [33:0]   gap_d, gap_h;
   logic [FW-1:0]        lim;
   logic [FW:0]          n_inc;
   logic [FW-1:0]        pos;
   logic [HW-1:0]        idx;
   logic signed [NUM_W-1:0] prod;
   logic signed [31:0]   sp_sat;

   function automatic logic [1:0] classify(input logic signed [31:0] s,
                                           input logic [30:0] db);
      logic signed [32:0] s33, d33;
      s33 = 33'(s);
      d33 = {2'b00, db};
      if (s33 > d33) return MV_FASTER;
      else if (s33 < -d33) return MV_SLOWER;
      else return MV_STABLE;
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      os_in         = os_ff;
      oe_in         = oe_ff;
      es_in         = es_ff;
      ee_in         = ee_ff;
      gap_in        = gap_ff;
      seq_in        = seq_ff;
      scan_idx_in   = scan_idx_ff;
      cmp_idx_in    = cmp_idx_ff;
      issue_done_in = issue_done_ff;
      cmp_pend_in   = 1'b0;
      found_in      = found_ff;
      free_ok_in    = free_ok_ff;
      free_idx_in   = free_idx_ff;
      slot_in       = slot_ff;
      m_stamp_in    = m_stamp_ff;
      m_fill_in     = m_fill_ff;
      m_head_in     = m_head_ff;
      m_spd_in      = m_spd_ff;
      m_ok_in       = m_ok_ff;
      nfill_in      = nfill_ff;
      nhead_in      = nhead_ff;
      cnt_in        = cnt_ff;
      rd_k_in       = rd_k_ff;
      acc_in        = acc_ff;
      neg_in        = neg_ff;
      r_move_in     = r_move_ff;
      r_stat_in     = r_stat_ff;
      r_spd_in      = r_spd_ff;
      r_sv_in       = r_sv_ff;
      r_rem_in      = r_rem_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_move_in   = rsp_move_ff;
      rsp_stat_in   = rsp_stat_ff;
      rsp_spd_in    = rsp_spd_ff;
      rsp_sv_in     = rsp_sv_ff;
      rsp_rem_in    = rsp_rem_ff;
      vset          = 1'b0;
      vclr          = 1'b0;
      vset_idx      = free_idx_ff;
      vclr_idx      = cmp_idx_ff;
      meta_we       = 1'b0;
      meta_wa       = slot_ff;
      meta_ra       = scan_idx_ff;
      w_stamp       = seq_ff;
      w_fill        = nfill_ff;
      w_head        = nhead_ff;
      w_spd         = '0;
      w_ok          = 1'b0;
      hist_we       = 1'b0;
      hist_wa       = '0;
      hist_ra       = '0;
      div_start     = 1'b0;
      div_num       = '0;
      div_den       = DEN_W'(AVG_COUNT * (int'(nfill_ff) - AVG_COUNT));
      gap_d         = (34'(os_ff) + 34'(oe_ff)) - (34'(es_ff) + 34'(ee_ff));
      gap_h         = gap_d >>> 1;
      lim           = FW'(WINDOW_DEPTH);
      n_inc         = (FW+1)'(m_fill_ff) + (FW+1)'(1);
      pos           = '0;
      idx           = '0;
      prod          = (NUM_W'(acc_ff) <<< 3) + (NUM_W'(acc_ff) <<< 1);
      sp_sat        = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_cmd;
               id_in     = req_obstacle_id;
               os_in     = req_obj_start_pos;
               oe_in     = req_obj_end_pos;
               es_in     = req_ego_start_pos;
               ee_in     = req_ego_end_pos;
               r_move_in = MV_UNKNOWN;
               r_stat_in = STAT_UPDATED;
               r_spd_in  = '0;
               r_sv_in   = 1'b0;
               r_rem_in  = '0;
               scan_idx_in   = '0;
               issue_done_in = 1'b0;
               found_in      = 1'b0;
               free_ok_in    = 1'b0;
               cnt_in        = '0;
               case (req_cmd)
                  CMD_OBSERVE: state_in = S_GAP;
                  CMD_ADVANCE: begin
                     seq_in   = seq_ff + 32'd1;
                     state_in = S_DONE;
                  end
                  CMD_PURGE:   state_in = S_SCAN;
                  default:     state_in = S_DONE;
               endcase
            end
         end
         S_GAP: begin
            if (gap_h > GAP_MAX) gap_in = GAP_MAX[POS_WIDTH-1:0];
            else if (gap_h < GAP_MIN) gap_in = GAP_MIN[POS_WIDTH-1:0];
            else gap_in = gap_h[POS_WIDTH-1:0];
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (!issue_done_ff) begin
               cmp_pend_in = 1'b1;
               cmp_idx_in  = scan_idx_ff;
               if (scan_idx_ff == SW'(MAX_OBJECTS - 1)) issue_done_in = 1'b1;
               else scan_idx_in = scan_idx_ff + SW'(1);
            end
            if (cmp_pend_ff) begin
               if (cmd_ff == CMD_PURGE) begin
                  if (valid_ff[cmp_idx_ff] && q_stamp != seq_ff) begin
                     vclr = 1'b1;
                     if (cnt_ff != 7'd127) cnt_in = cnt_ff + 7'd1;
                  end
                  if (cmp_idx_ff == SW'(MAX_OBJECTS - 1)) begin
                     r_rem_in = (valid_ff[cmp_idx_ff] && q_stamp != seq_ff
                                 && cnt_ff != 7'd127) ? cnt_ff + 7'd1 : cnt_ff;
                     state_in = S_DONE;
                  end
               end else begin
                  if (valid_ff[cmp_idx_ff] && q_ident == id_ff) begin
                     found_in   = 1'b1;
                     slot_in    = cmp_idx_ff;
                     m_stamp_in = q_stamp;
                     m_fill_in  = q_fill;
                     m_head_in  = q_head;
                     m_spd_in   = q_spd;
                     m_ok_in    = q_ok;
                     state_in   = S_RESOLVE;
                  end else begin
                     if (!valid_ff[cmp_idx_ff] && !free_ok_ff) begin
                        free_ok_in  = 1'b1;
                        free_idx_in = cmp_idx_ff;
                     end
                     if (cmp_idx_ff == SW'(MAX_OBJECTS - 1)) state_in = S_RESOLVE;
                  end
               end
            end
         end
         S_RESOLVE: begin
            if (found_ff) begin
               if (m_stamp_ff != seq_ff) begin
                  state_in = S_APPEND;
               end else begin
                  r_stat_in = STAT_REPEAT;
                  if (m_ok_ff) begin
                     r_move_in = classify(m_spd_ff, deadband_ff);
                     r_spd_in  = m_spd_ff;
                     r_sv_in   = 1'b1;
                  end
                  state_in = S_DONE;
               end
            end else if (free_ok_ff) begin
               meta_we   = 1'b1;
               meta_wa   = free_idx_ff;
               w_fill    = FW'(1);
               w_head    = '0;
               hist_we   = 1'b1;
               hist_wa   = HAW'(free_idx_ff) * HAW'(WINDOW_DEPTH);
               vset      = 1'b1;
               r_stat_in = STAT_NEW;
               state_in  = S_DONE;
            end else begin
               r_stat_in = STAT_FULL;
               state_in  = S_DONE;
            end
         end
         S_APPEND: begin
            if (wlimit_ff == 5'd0) lim = FW'(1);
            else if (32'(wlimit_ff) > 32'(WINDOW_DEPTH)) lim = FW'(WINDOW_DEPTH);
            else lim = FW'(wlimit_ff);
            hist_we = 1'b1;
            hist_wa = HAW'(slot_ff) * HAW'(WINDOW_DEPTH)
                      + HAW'(wrap_idx(m_head_ff, m_fill_ff));
            if (n_inc > (FW+1)'(lim)) begin
               w_fill = m_fill_ff;
               w_head = wrap_idx(m_head_ff, FW'(1));
            end else begin
               w_fill = n_inc[FW-1:0];
               w_head = m_head_ff;
            end
            meta_we  = 1'b1;
            nfill_in = w_fill;
            nhead_in = w_head;
            acc_in   = '0;
            rd_k_in  = '0;
            if (32'(w_fill) >= 32'(MIN_FILL) && 32'(w_fill) > 32'(AVG_COUNT))
               state_in = S_RD;
            else
               state_in = S_DONE;
         end
         S_RD: begin
            if (32'(rd_k_ff) < 32'(AVG_COUNT)) pos = FW'(rd_k_ff);
            else pos = FW'(int'(nfill_ff) - 1 - (int'(rd_k_ff) - AVG_COUNT));
            idx      = wrap_idx(nhead_ff, pos);
            hist_ra  = HAW'(slot_ff) * HAW'(WINDOW_DEPTH) + HAW'(idx);
            state_in = S_ACC;
         end
         S_ACC: begin
            if (32'(rd_k_ff) < 32'(AVG_COUNT)) acc_in = acc_ff - ACC_W'(hist_q);
            else acc_in = acc_ff + ACC_W'(hist_q);
            if (32'(rd_k_ff) == 32'(2 * AVG_COUNT - 1)) begin
               state_in = S_DIV_GO;
            end else begin
               rd_k_in  = rd_k_ff + K_W'(1);
               state_in = S_RD;
            end
         end
         S_DIV_GO: begin
            div_start = 1'b1;
            neg_in    = prod[NUM_W-1];
            div_num   = prod[NUM_W-1] ? NUM_W'(-prod) : NUM_W'(prod);
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_sts.done) begin
               if (neg_ff) begin
                  if (div_quot > NUM_W'(33'h0_8000_0000)) sp_sat = 32'sh8000_0000;
                  else sp_sat = -(div_quot[31:0]);
               end else begin
                  if (div_quot > NUM_W'(32'h7FFF_FFFF)) sp_sat = 32'sh7FFF_FFFF;
                  else sp_sat = div_quot[31:0];
               end
               meta_we   = 1'b1;
               w_spd     = sp_sat;
               w_ok      = 1'b1;
               r_move_in = classify(sp_sat, deadband_ff);
               r_spd_in  = sp_sat;
               r_sv_in   = 1'b1;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_move_in  = r_move_ff;
               rsp_stat_in  = r_stat_ff;
               rsp_spd_in   = r_spd_ff;
               rsp_sv_in    = r_sv_ff;
               rsp_rem_in   = r_rem_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         ident_mem[meta_wa] <= id_ff;
         stamp_mem[meta_wa] <= w_stamp;
         fill_mem[meta_wa]  <= w_fill;
         head_mem[meta_wa]  <= w_head;
         spd_mem[meta_wa]   <= w_spd;
         ok_mem[meta_wa]    <= w_ok;
      end
      q_ident <= ident_mem[meta_ra];
      q_stamp <= stamp_mem[meta_ra];
      q_fill  <= fill_mem[meta_ra];
      q_head  <= head_mem[meta_ra];
      q_spd   <= spd_mem[meta_ra];
      q_ok    <= ok_mem[meta_ra];
   end

   always_ff @(posedge clock) begin
      if (hist_we) hist_mem[hist_wa] <= gap_ff;
      hist_q <= hist_mem[hist_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (vset) valid_ff[vset_idx] <= 1'b1;
         if (vclr) valid_ff[vclr_idx] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff <= 31'd128;
         wlimit_ff   <= 5'd16;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DEADBAND: deadband_ff <= csr_wdata;
            CSR_WLIMIT:   wlimit_ff   <= csr_wdata[4:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         seq_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         issue_done_ff <= 1'b0;
         cmp_pend_ff   <= 1'b0;
         found_ff      <= 1'b0;
         free_ok_ff    <= 1'b0;
         cnt_ff        <= '0;
         rd_k_ff       <= '0;
         scan_idx_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         seq_ff        <= seq_in;
         rsp_valid_ff  <= rsp_valid_in;
         issue_done_ff <= issue_done_in;
         cmp_pend_ff   <= cmp_pend_in;
         found_ff      <= found_in;
         free_ok_ff    <= free_ok_in;
         cnt_ff        <= cnt_in;
         rd_k_ff       <= rd_k_in;
         scan_idx_ff   <= scan_idx_in;
      end
      cmd_ff      <= cmd_in;
      id_ff       <= id_in;
      os_ff       <= os_in;
      oe_ff       <= oe_in;
      es_ff       <= es_in;
      ee_ff       <= ee_in;
      gap_ff      <= gap_in;
      cmp_idx_ff  <= cmp_idx_in;
      free_idx_ff <= free_idx_in;
      slot_ff     <= slot_in;
      m_stamp_ff  <= m_stamp_in;
      m_fill_ff   <= m_fill_in;
      m_head_ff   <= m_head_in;
      m_spd_ff    <= m_spd_in;
      m_ok_ff     <= m_ok_in;
      nfill_ff    <= nfill_in;
      nhead_ff    <= nhead_in;
      acc_ff      <= acc_in;
      neg_ff      <= neg_in;
      r_move_ff   <= r_move_in;
      r_stat_ff   <= r_stat_in;
      r_spd_ff    <= r_spd_in;
      r_sv_ff     <= r_sv_in;
      r_rem_ff    <= r_rem_in;
      rsp_move_ff <= rsp_move_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_spd_ff  <= rsp_spd_in;
      rsp_sv_ff   <= rsp_sv_in;
      rsp_rem_ff  <= rsp_rem_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_move_state     = rsp_move_ff;
   assign rsp_gap_rate       = rsp_spd_ff;
   assign rsp_speed_valid    = rsp_sv_ff;
   assign rsp_status         = rsp_stat_ff;
   assign rsp_removed_count  = rsp_rem_ff;

endmodule
